[rtl/sorted_piece_list_top_defines.svh]
// ---------------------------------------------------------------------------
// Sorted piece list assertion macros
// Shared property forms for the concurrent checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef SORTED_PIECE_LIST_TOP_DEFINES_SVH
`define SORTED_PIECE_LIST_TOP_DEFINES_SVH

// Same-cycle implication, checked on aclk and disabled while in reset.
`define SPL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk and disabled while in reset.
`define SPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/spl_pkg.sv]
// ---------------------------------------------------------------------------
// Sorted piece list package
// Entry and result types, operation and status codes, and the sort order.
// ---------------------------------------------------------------------------
package spl_pkg;

    // Default number of entries the table holds.
    localparam int DEPTH_DEFAULT = 32;

    // Operation codes carried on s_tuser.
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_HEAD   = 2'd2;

    // Type code that marks a blank square.
    localparam logic signed [7:0] KIND_BLANK = -8'sd1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BLANK   = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0]       weight;
        logic [2:0]        row;
        logic [2:0]        col;
        logic signed [7:0] kind;
        logic              computer;
        logic              moved;
    } entry_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  count;
        entry_t      head;
    } result_t;

    // Commands from the controller to the cell row.
    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_UPDATE
    } state_t;

    // True when entry a must stand before entry b: weight descending,
    // then row ascending, then column ascending.
    function automatic logic goes_before(input entry_t a, input entry_t b);
        logic res;
        if (a.weight != b.weight) begin
            res = (a.weight > b.weight);
        end else if (a.row != b.row) begin
            res = (a.row < b.row);
        end else begin
            res = (a.col < b.col);
        end
        return res;
    endfunction

endpackage

[rtl/spl_ctrl.sv]
// ---------------------------------------------------------------------------
// Sorted piece list controller
// Sequences accept, compare and update, and owns the result handshake.
// ---------------------------------------------------------------------------
`include "sorted_piece_list_top_defines.svh"

module spl_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output spl_pkg::cmd_t cmd
);

    spl_pkg::state_t state_reg;
    spl_pkg::state_t state_next;
    logic            m_valid_reg;
    logic            m_valid_next;
    logic            out_free;
    logic            accept;

    // The result register can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spl_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = spl_pkg::S_COMPARE;
                end
            end
            spl_pkg::S_COMPARE: begin
                state_next = spl_pkg::S_UPDATE;
            end
            spl_pkg::S_UPDATE: begin
                if (out_free) begin
                    state_next = accept ? spl_pkg::S_COMPARE : spl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = spl_pkg::S_IDLE;
            end
        endcase
    end

    // Output logic: a new item may enter while the previous one commits.
    always_comb begin
        s_tready    = 1'b0;
        cmd.compare = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            spl_pkg::S_IDLE: begin
                s_tready = 1'b1;
            end
            spl_pkg::S_COMPARE: begin
                cmd.compare = 1'b1;
            end
            spl_pkg::S_UPDATE: begin
                s_tready   = out_free;
                cmd.commit = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        cmd.load = s_tvalid && s_tready;
    end

    // Result valid is set by a commit and cleared by a transfer.
    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spl_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A transfer in only happens when no comparison is in progress.
    `SPL_ASSERT_IMPL(a_accept_state, accept, state_reg != spl_pkg::S_COMPARE, "input taken during compare")
    // A commit never overwrites a result that is still waiting.
    `SPL_ASSERT_IMPL(a_commit_free, cmd.commit, !m_valid_reg || m_tready, "result overwritten")
    // Every comparison is followed by the update step.
    `SPL_ASSERT_NEXT(a_compare_then_update, state_reg == spl_pkg::S_COMPARE, state_reg == spl_pkg::S_UPDATE, "compare not followed by update")
    // A commit always presents a result in the next cycle.
    `SPL_ASSERT_NEXT(a_commit_valid, cmd.commit, m_valid_reg, "commit without result")

endmodule

[rtl/spl_cells.sv]
// ---------------------------------------------------------------------------
// Sorted piece list cell row
// A row of entry cells with per-cell compare and neighbor shift, plus the
// operation register and the result register.
// ---------------------------------------------------------------------------
module spl_cells #(
    parameter int DEPTH = spl_pkg::DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  spl_pkg::cmd_t     cmd,
    input  logic [1:0]        in_func,
    input  spl_pkg::entry_t   in_entry,
    output spl_pkg::result_t  result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LV = $clog2(DEPTH);

    logic [1:0]           func_reg;
    spl_pkg::entry_t      op_reg;
    spl_pkg::entry_t      cell_reg [DEPTH];
    spl_pkg::entry_t      cell_next [DEPTH];
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [DEPTH-1:0]     ge_reg;
    logic [DEPTH-1:0]     ge_next;
    logic [DEPTH-1:0]     match_reg;
    logic [DEPTH-1:0]     match_next;
    logic [DEPTH-1:0]     pfx [LV+1];
    logic                 found;
    logic                 is_empty;
    logic                 is_full;
    logic                 is_blank;
    logic                 do_ins;
    logic                 do_rm;
    spl_pkg::status_t     status_next;
    spl_pkg::result_t     result_reg;

    // Per-cell compare: insertion boundary and removal match.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i) < count_reg) begin
                ge_next[i]    = spl_pkg::goes_before(op_reg, cell_reg[i]);
                match_next[i] = (cell_reg[i].row == op_reg.row) &&
                                (cell_reg[i].col == op_reg.col);
            end else begin
                ge_next[i]    = 1'b1;
                match_next[i] = 1'b0;
            end
        end
    end

    // Inclusive prefix OR of the match flags, log-depth.
    always_comb begin
        pfx[0] = match_reg;
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
                end else begin
                    pfx[l+1][i] = pfx[l][i];
                end
            end
        end
    end

    assign found    = pfx[LV][DEPTH-1];
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_blank = (op_reg.kind == spl_pkg::KIND_BLANK);
    assign do_ins   = (func_reg == spl_pkg::FN_INSERT) && !is_blank && !is_full;
    assign do_rm    = (func_reg == spl_pkg::FN_REMOVE) && !is_empty && found;

    // Status of the operation.
    always_comb begin
        status_next = spl_pkg::ST_OK;
        case (func_reg)
            spl_pkg::FN_INSERT: begin
                if (is_blank) begin
                    status_next = spl_pkg::ST_BLANK;
                end else if (is_full) begin
                    status_next = spl_pkg::ST_FULL;
                end
            end
            spl_pkg::FN_REMOVE: begin
                if (is_empty) begin
                    status_next = spl_pkg::ST_EMPTY;
                end else if (!found) begin
                    status_next = spl_pkg::ST_MISSING;
                end
            end
            spl_pkg::FN_HEAD: begin
                if (is_empty) begin
                    status_next = spl_pkg::ST_EMPTY;
                end
            end
            default: begin
                status_next = spl_pkg::ST_OK;
            end
        endcase
    end

    // Cell update: insert shifts toward the tail, remove toward the head.
    always_comb begin
        count_next = count_reg;
        for (int i = 0; i < DEPTH; i++) begin
            cell_next[i] = cell_reg[i];
        end
        if (do_ins) begin
            count_next = count_reg + CW'(1);
            if (ge_reg[0]) begin
                cell_next[0] = op_reg;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (ge_reg[i - 1]) begin
                    cell_next[i] = cell_reg[i - 1];
                end else if (ge_reg[i]) begin
                    cell_next[i] = op_reg;
                end
            end
        end else if (do_rm) begin
            count_next = count_reg - CW'(1);
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (pfx[LV][i]) begin
                    cell_next[i] = cell_reg[i + 1];
                end
            end
        end
    end

    // Operation capture, compare flags and cell contents.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            op_reg   <= in_entry;
        end
        if (cmd.compare) begin
            ge_reg    <= ge_next;
            match_reg <= match_next;
        end
        if (cmd.commit) begin
            for (int i = 0; i < DEPTH; i++) begin
                cell_reg[i] <= cell_next[i];
            end
            result_reg.status <= status_next;
            result_reg.count  <= 6'(count_next);
            result_reg.head   <= (count_next != '0) ? cell_next[0] : '0;
        end
    end

    // Fill count is the only register of the table that reset clears.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    assign result = result_reg;

endmodule

[rtl/sorted_piece_list_top.sv]
// An input is registered in the operation register, compared per cell into the
// compare flags, then prefix-searched and shifted across the cell row as it
// commits to the result register; a new item is taken as the previous one commits.
// A stalled result holds the update step until the result register drains.
// Reset clears the fill count and the handshake state; cell contents are
// not cleared and no clearing pass is needed.
// ---------------------------------------------------------------------------
// Sorted piece list top level
// Keeps entries sorted by weight, row and column; inserts, removes and
// reports the head entry over stream channels.
// ---------------------------------------------------------------------------
module sorted_piece_list_top #(
    parameter int DEPTH = spl_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: piece_weight[15:0], row_index[18:16], col_index[21:19],
    //        piece_kind[29:22], owned_by_computer[30], moved_flag[31]
    input  logic [31:0] s_tdata,
    // tuser: func[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: status[2:0], entry_count[8:3], head_weight[24:9],
    //        head_row[27:25], head_col[30:28], head_kind[38:31],
    //        head_computer[39], head_moved[40], zero fill[47:41]
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    spl_pkg::cmd_t    cmd;
    spl_pkg::entry_t  in_entry;
    spl_pkg::result_t result;

    // Unpack the input transfer into an entry.
    always_comb begin
        in_entry.weight   = s_tdata[15:0];
        in_entry.row      = s_tdata[18:16];
        in_entry.col      = s_tdata[21:19];
        in_entry.kind     = s_tdata[29:22];
        in_entry.computer = s_tdata[30];
        in_entry.moved    = s_tdata[31];
    end

    spl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    spl_cells #(
        .DEPTH (DEPTH)
    ) u_cells (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_func  (s_tuser),
        .in_entry (in_entry),
        .result   (result)
    );

    // Pack the result register onto the output transfer.
    always_comb begin
        m_tdata        = '0;
        m_tdata[2:0]   = result.status;
        m_tdata[8:3]   = result.count;
        m_tdata[24:9]  = result.head.weight;
        m_tdata[27:25] = result.head.row;
        m_tdata[30:28] = result.head.col;
        m_tdata[38:31] = result.head.kind;
        m_tdata[39]    = result.head.computer;
        m_tdata[40]    = result.head.moved;
    end

endmodule
